[design/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, defaults and the hue sextant code for the HSV to packed
// RGBA converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int IN_W          = 18;  // width of each signed input field
    localparam int OUT_W         = 32;  // packed A/B/G/R word
    localparam int BYTE_W        = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Hue sextant, red at the start of the circle
    typedef enum logic [2:0] {
        SEXT_RED_YEL = 3'd0,
        SEXT_YEL_GRN = 3'd1,
        SEXT_GRN_CYN = 3'd2,
        SEXT_CYN_BLU = 3'd3,
        SEXT_BLU_MAG = 3'd4,
        SEXT_MAG_RED = 3'd5
    } sextant_t;

endpackage

[design/hsvrgb_in_if.sv]
// ----------------------------------------------------------------------------
// hsvrgb_in_if
// Input channel: one HSV plus alpha quadruple per transaction.
// ----------------------------------------------------------------------------
interface hsvrgb_in_if;

    logic                                    valid;
    logic                                    ready;
    logic signed [hsvrgb_pkg::IN_W-1:0]      hue;
    logic signed [hsvrgb_pkg::IN_W-1:0]      saturation;
    logic signed [hsvrgb_pkg::IN_W-1:0]      brightness;
    logic signed [hsvrgb_pkg::IN_W-1:0]      alpha;

    modport source (output valid, output hue, output saturation, output brightness,
                    output alpha, input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    input alpha, output ready);

endinterface

[design/hsvrgb_out_if.sv]
// ----------------------------------------------------------------------------
// hsvrgb_out_if
// Output channel: one packed color word per transaction.
// ----------------------------------------------------------------------------
interface hsvrgb_out_if;

    logic                            valid;
    logic                            ready;
    logic [hsvrgb_pkg::OUT_W-1:0]    packed_color;

    modport source (output valid, output packed_color, input ready);
    modport sink   (input valid, input packed_color, output ready);

endinterface

[design/hsv_to_rgb_packed.sv]
// Throughput: one transaction per cycle unless the output stalls; five register
// stages (clamp, hue split and p product, S*f products, q/t products, channel
// select and byte scale). Each stage holds while the stage after it is full
// and stalled; bubbles close. Reset (rst_n low, asynchronous) clears all stage
// valid bits; data regs keep X.
// ----------------------------------------------------------------------------
// hsv_to_rgb_packed
// HSV plus alpha in signed fixed point to a packed A/B/G/R 32-bit color word.
// ----------------------------------------------------------------------------
module hsv_to_rgb_packed #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hsvrgb_in_if.sink            hsv,
    hsvrgb_out_if.source         rgb
);

    localparam int UW     = FRAC_BITS + 1;         // unit value 0..ONE
    localparam int HW     = FRAC_BITS + 3;         // hue * 6
    localparam int PW     = 2 * UW;                // full product
    localparam int BYTE_W = hsvrgb_pkg::BYTE_W;
    localparam int BW     = UW + BYTE_W;           // x * 255
    localparam logic [UW-1:0] ONE       = UW'(1) << FRAC_BITS;
    localparam logic [2:0]    HUE_WRAP  = 3'd6;    // hue of exactly one

    // x * 255 >> FRAC_BITS, x in 0..ONE
    function automatic logic [BYTE_W-1:0] to_byte(input logic [UW-1:0] x);
        logic [BW-1:0] prod;
        prod = {x, {BYTE_W{1'b0}}} - BW'(x);
        return prod[FRAC_BITS +: BYTE_W];
    endfunction

    // stage handshake
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5      = !vld5_reg || rgb.ready;
    assign adv4      = !vld4_reg || adv5;
    assign adv3      = !vld3_reg || adv4;
    assign adv2      = !vld2_reg || adv3;
    assign adv1      = !vld1_reg || adv2;
    assign hsv.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            if (adv1) vld1_reg <= hsv.valid;
            if (adv2) vld2_reg <= vld1_reg;
            if (adv3) vld3_reg <= vld2_reg;
            if (adv4) vld4_reg <= vld3_reg;
            if (adv5) vld5_reg <= vld4_reg;
        end
    end

    // ---------------- stage 1: clamp ----------------
    logic [UW-1:0] h1_next, s1_next, v1_next, a1_next;
    logic [UW-1:0] h1_reg,  s1_reg,  v1_reg,  a1_reg;

    hsvrgb_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp_h (.raw(hsv.hue),        .val(h1_next));
    hsvrgb_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp_s (.raw(hsv.saturation), .val(s1_next));
    hsvrgb_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp_v (.raw(hsv.brightness), .val(v1_next));
    hsvrgb_clamp #(.FRAC_BITS(FRAC_BITS)) u_clamp_a (.raw(hsv.alpha),      .val(a1_next));

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            h1_reg <= h1_next;
            s1_reg <= s1_next;
            v1_reg <= v1_next;
            a1_reg <= a1_next;
        end
    end

    // ---------------- stage 2: hue split, p product, alpha byte ----------------
    logic [HW-1:0]          hh;
    logic [2:0]             hue_int;
    hsvrgb_pkg::sextant_t   sext2_next, sext2_reg;
    logic [FRAC_BITS-1:0]   f2_next, f2_reg;
    logic [UW-1:0]          omf2_next, omf2_reg;
    logic [PW-1:0]          pprod2_next, pprod2_reg;
    logic [UW-1:0]          s2_reg, v2_reg;
    logic [BYTE_W-1:0]      abyte2_next, abyte2_reg;

    assign hh          = {h1_reg, 2'b00} + HW'({h1_reg, 1'b0});
    assign hue_int     = hh[HW-1:FRAC_BITS];
    assign sext2_next  = (hue_int == HUE_WRAP) ? hsvrgb_pkg::SEXT_RED_YEL
                                               : hsvrgb_pkg::sextant_t'(hue_int);
    assign f2_next     = hh[FRAC_BITS-1:0];
    assign omf2_next   = ONE - UW'(f2_next);
    assign pprod2_next = PW'(v1_reg) * PW'(ONE - s1_reg);
    assign abyte2_next = to_byte(a1_reg);

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            sext2_reg  <= sext2_next;
            f2_reg     <= f2_next;
            omf2_reg   <= omf2_next;
            pprod2_reg <= pprod2_next;
            s2_reg     <= s1_reg;
            v2_reg     <= v1_reg;
            abyte2_reg <= abyte2_next;
        end
    end

    // ---------------- stage 3: S*f and S*(1-f) ----------------
    logic [PW-1:0]          sf_prod, snf_prod;
    logic [UW-1:0]          sf3_next, snf3_next, p3_next;
    logic [UW-1:0]          sf3_reg, snf3_reg, p3_reg, v3_reg;
    hsvrgb_pkg::sextant_t   sext3_reg;
    logic [BYTE_W-1:0]      abyte3_reg;

    assign sf_prod   = PW'(s2_reg) * PW'(f2_reg);
    assign snf_prod  = PW'(s2_reg) * PW'(omf2_reg);
    assign sf3_next  = sf_prod[FRAC_BITS +: UW];
    assign snf3_next = snf_prod[FRAC_BITS +: UW];
    assign p3_next   = pprod2_reg[FRAC_BITS +: UW];

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            sf3_reg    <= sf3_next;
            snf3_reg   <= snf3_next;
            p3_reg     <= p3_next;
            v3_reg     <= v2_reg;
            sext3_reg  <= sext2_reg;
            abyte3_reg <= abyte2_reg;
        end
    end

    // ---------------- stage 4: q and t ----------------
    logic [PW-1:0]          q_prod, t_prod;
    logic [UW-1:0]          q4_next, t4_next;
    logic [UW-1:0]          q4_reg, t4_reg, p4_reg, v4_reg;
    hsvrgb_pkg::sextant_t   sext4_reg;
    logic [BYTE_W-1:0]      abyte4_reg;

    assign q_prod  = PW'(v3_reg) * PW'(ONE - sf3_reg);
    assign t_prod  = PW'(v3_reg) * PW'(ONE - snf3_reg);
    assign q4_next = q_prod[FRAC_BITS +: UW];
    assign t4_next = t_prod[FRAC_BITS +: UW];

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            q4_reg     <= q4_next;
            t4_reg     <= t4_next;
            p4_reg     <= p3_reg;
            v4_reg     <= v3_reg;
            sext4_reg  <= sext3_reg;
            abyte4_reg <= abyte3_reg;
        end
    end

    // ---------------- stage 5: channel select, byte scale, pack ----------------
    logic [UW-1:0]          red, green, blue;
    logic [hsvrgb_pkg::OUT_W-1:0] color_next, color_reg;

    always_comb
    begin
        unique case (sext4_reg)
            hsvrgb_pkg::SEXT_RED_YEL:
            begin
                red = v4_reg; green = t4_reg; blue = p4_reg;
            end
            hsvrgb_pkg::SEXT_YEL_GRN:
            begin
                red = q4_reg; green = v4_reg; blue = p4_reg;
            end
            hsvrgb_pkg::SEXT_GRN_CYN:
            begin
                red = p4_reg; green = v4_reg; blue = t4_reg;
            end
            hsvrgb_pkg::SEXT_CYN_BLU:
            begin
                red = p4_reg; green = q4_reg; blue = v4_reg;
            end
            hsvrgb_pkg::SEXT_BLU_MAG:
            begin
                red = t4_reg; green = p4_reg; blue = v4_reg;
            end
            default:
            begin
                red = v4_reg; green = p4_reg; blue = q4_reg;
            end
        endcase
    end

    assign color_next = {abyte4_reg, to_byte(blue), to_byte(green), to_byte(red)};

    always_ff @(posedge clk)
    begin
        if (adv5)
            color_reg <= color_next;
    end

    assign rgb.valid        = vld5_reg;
    assign rgb.packed_color = color_reg;

endmodule

[design/hsvrgb_clamp.sv]
// ----------------------------------------------------------------------------
// hsvrgb_clamp
// Clamps a signed fixed-point input to the unit range 0..ONE.
// ----------------------------------------------------------------------------
module hsvrgb_clamp #(
    parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
    input  logic signed [hsvrgb_pkg::IN_W-1:0] raw,
    output logic        [FRAC_BITS:0]          val
);

    localparam int IN_W = hsvrgb_pkg::IN_W;
    // compare width: holds the raw magnitude and ONE with room to spare
    localparam int CW   = (IN_W > FRAC_BITS + 1) ? IN_W : FRAC_BITS + 2;
    localparam logic [CW-1:0]        ONE_C = CW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]   ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [CW-1:0] ext;

    assign ext = CW'($unsigned(raw));

    always_comb
    begin
        if (raw[IN_W-1])
            val = '0;
        else if (ext > ONE_C)
            val = ONE;
        else
            val = ext[FRAC_BITS:0];
    end

endmodule
